// ----- hw/rtl/dmf_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dmf_pkg
// Shared constants and types of the delimiter message framer.
// ============================================================================
package dmf_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SEP_W       = 64;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned BATCH_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_SEPARATOR   = 2'd2;

    localparam logic [SEP_W-1:0] SEPARATOR_BYTES_RESET  = 64'd10;
    localparam logic [LEN_W-1:0] SEPARATOR_LENGTH_RESET = 4'd1;

    // Describes the group of beats that one input byte produces.
    typedef struct packed {
        logic [BATCH_CNT_W-1:0] count;
        logic                   marker;
        logic                   eom;
    } batch_t;

endpackage

// ----- hw/rtl/dmf_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dmf_byte_if / dmf_msg_if
// Valid/ready channels for the input byte stream and the message beats.
// ============================================================================
interface dmf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dmf_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

// ----- hw/rtl/delimiter_message_framer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// delimiter_message_framer
// Cuts a byte stream into messages that end at a configurable separator.
// ============================================================================
//  Channel    Role     Payload
//  stream     sink     data_byte
//  messages   source   out_byte, byte_valid, end_of_message
//  cfg_*      write    cfg_index selects register, cfg_data holds the value
//
//  Each accepted byte is matched and its beats are registered as it is taken.
//  A byte that yields at most one beat lets the next byte enter the next cycle
//  if messages is ready. A byte that yields more beats holds the stream until
//  its last beat is taken; beats drain one per cycle while messages is ready.
//  Reset empties the pending window and the result register.
//  A stall on messages holds its beat and stops the stream once it is full.
// ============================================================================
module delimiter_message_framer #(
    parameter int unsigned MAX_SEPARATOR = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dmf_byte_if.sink                        stream,
    dmf_msg_if.source                       messages,
    input  logic                            cfg_we,
    input  logic [dmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [dmf_pkg::SEP_W-1:0] sep_bytes_reg;
    logic [dmf_pkg::LEN_W-1:0] sep_length_reg;
    logic                      trim_reg;
    logic [7:0]                batch_bytes [MAX_SEPARATOR+1];
    dmf_pkg::batch_t           batch;
    logic                      load_ok;
    logic                      accept;

    assign stream.ready = load_ok;
    assign accept       = stream.valid && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_bytes_reg  <= dmf_pkg::SEPARATOR_BYTES_RESET;
            sep_length_reg <= dmf_pkg::SEPARATOR_LENGTH_RESET;
            trim_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dmf_pkg::REG_SEPARATOR_BYTES:
                begin
                    sep_bytes_reg <= cfg_data[dmf_pkg::SEP_W-1:0];
                end
                dmf_pkg::REG_SEPARATOR_LENGTH:
                begin
                    sep_length_reg <= cfg_data[dmf_pkg::LEN_W-1:0];
                end
                dmf_pkg::REG_TRIM_SEPARATOR:
                begin
                    trim_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    dmf_window #(
        .MAX_SEPARATOR (MAX_SEPARATOR)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (stream.data_byte),
        .sep_bytes   (sep_bytes_reg),
        .sep_length  (sep_length_reg),
        .trim        (trim_reg),
        .batch_bytes (batch_bytes),
        .batch       (batch)
    );

    dmf_out_buf #(
        .MAX_SEPARATOR (MAX_SEPARATOR)
    ) u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_bytes (batch_bytes),
        .batch       (batch),
        .load_ok     (load_ok),
        .load        (accept),
        .messages    (messages)
    );

endmodule

// ----- hw/rtl/dmf_window.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dmf_window
// Pending byte window, separator match and per-byte beat group builder.
// ============================================================================
module dmf_window #(
    parameter int unsigned MAX_SEPARATOR = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic [dmf_pkg::SEP_W-1:0]  sep_bytes,
    input  logic [dmf_pkg::LEN_W-1:0]  sep_length,
    input  logic                       trim,
    output logic [7:0]                 batch_bytes [MAX_SEPARATOR+1],
    output dmf_pkg::batch_t            batch
);

    localparam int unsigned M  = MAX_SEPARATOR;
    localparam int unsigned CW = $clog2(M + 2);

    logic [7:0]    win_reg [M];
    logic [7:0]    win_next [M];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] release_cnt;
    logic [CW-1:0] kept_cnt;
    logic          match;

    always_comb
    begin
        if (sep_length == '0)
        begin
            len_eff = CW'(1);
        end
        else if (sep_length > dmf_pkg::LEN_W'(M))
        begin
            len_eff = CW'(M);
        end
        else
        begin
            len_eff = CW'(sep_length);
        end
    end

    // The old pending bytes followed by the new byte form the beat sequence.
    always_comb
    begin
        for (int i = 0; i < int'(M); i++)
        begin
            if (CW'(i) < count_reg)
            begin
                batch_bytes[i] = win_reg[i];
            end
            else
            begin
                batch_bytes[i] = data_byte;
            end
        end
        batch_bytes[M] = data_byte;
    end

    assign release_cnt = (count_reg >= len_eff) ? CW'(count_reg - len_eff + CW'(1)) : '0;
    assign kept_cnt    = CW'(count_reg + CW'(1) - release_cnt);

    always_comb
    begin
        for (int i = 0; i < int'(M); i++)
        begin
            win_next[i] = batch_bytes[M];
            for (int j = i; j <= int'(M); j++)
            begin
                if (CW'(j - i) == release_cnt)
                begin
                    win_next[i] = batch_bytes[j];
                end
            end
        end
    end

    always_comb
    begin
        match = (kept_cnt == len_eff);
        for (int i = 0; i < int'(M); i++)
        begin
            if (CW'(i) < len_eff && win_next[i] != sep_bytes[8*i +: 8])
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        batch.marker = 1'b0;
        batch.eom    = 1'b0;
        batch.count  = dmf_pkg::BATCH_CNT_W'(release_cnt);
        count_next   = kept_cnt;
        if (match)
        begin
            batch.eom  = 1'b1;
            count_next = '0;
            if (trim)
            begin
                batch.marker = 1'b1;
                batch.count  = dmf_pkg::BATCH_CNT_W'(release_cnt + CW'(1));
            end
            else
            begin
                batch.count = dmf_pkg::BATCH_CNT_W'(count_reg + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ----- hw/rtl/dmf_out_buf.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dmf_out_buf
// Result register that holds one beat group and shifts it out beat by beat.
// ============================================================================
module dmf_out_buf #(
    parameter int unsigned MAX_SEPARATOR = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       batch_bytes [MAX_SEPARATOR+1],
    input  dmf_pkg::batch_t  batch,
    output logic             load_ok,
    input  logic             load,
    dmf_msg_if.source        messages
);

    localparam int unsigned D = MAX_SEPARATOR + 1;

    logic [7:0]                      buf_reg [D];
    logic [dmf_pkg::BATCH_CNT_W-1:0] cnt_reg;
    logic [dmf_pkg::BATCH_CNT_W-1:0] cnt_next;
    logic                            marker_reg;
    logic                            eom_reg;
    logic                            last;
    logic                            pop;

    assign last    = (cnt_reg == dmf_pkg::BATCH_CNT_W'(1));
    assign pop     = messages.valid && messages.ready;
    assign load_ok = (cnt_reg == '0) || (last && messages.ready);

    assign messages.valid          = (cnt_reg != '0);
    assign messages.byte_valid     = !(last && marker_reg);
    assign messages.out_byte       = (last && marker_reg) ? 8'd0 : buf_reg[0];
    assign messages.end_of_message = last && eom_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - dmf_pkg::BATCH_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            marker_reg <= 1'b0;
            eom_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load)
            begin
                marker_reg <= batch.marker;
                eom_reg    <= batch.eom;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= batch_bytes;
        end
        else if (pop)
        begin
            for (int i = 0; i + 1 < int'(D); i++)
            begin
                buf_reg[i] <= buf_reg[i + 1];
            end
        end
    end

endmodule

// ----- hw/rtl/dmf_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// dmf_checker
// Port-level checks of the delimiter message framer, bound to the top level.
// ============================================================================
module dmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       end_of_message
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(end_of_message))
        else $error("Stalled output beat changed.");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> end_of_message && out_byte == 8'd0)
        else $error("Bare end marker is malformed.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Input stalled with no pending output.");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("Input taken while output is stalled.");

endmodule

bind delimiter_message_framer dmf_checker u_dmf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (stream.valid),
    .in_ready       (stream.ready),
    .out_valid      (messages.valid),
    .out_ready      (messages.ready),
    .out_byte       (messages.out_byte),
    .byte_valid     (messages.byte_valid),
    .end_of_message (messages.end_of_message)
);
